@@ design/sfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the stream find-and-replace modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int PAT_MAX   = 8;
	localparam int REP_MAX   = 8;
	localparam int WIN_DEPTH = 8;
	localparam int CNT_W     = 4;
	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PATTERN_LEN       = 2'd0,
		REG_PATTERN_BYTES     = 2'd1,
		REG_REPLACEMENT_LEN   = 2'd2,
		REG_REPLACEMENT_BYTES = 2'd3
	} sfr_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_REPL,
		ST_FLUSH,
		ST_TERM
	} sfr_state_t;

	typedef enum logic [1:0] {
		EMIT_WIN,
		EMIT_REP,
		EMIT_TERM
	} sfr_emit_t;

	typedef struct packed {
		logic      push;
		logic      pop;
		logic      clear;
		logic      emit;
		sfr_emit_t sel;
		logic      emit_last;
		logic      rep_rst;
		logic      rep_inc;
	} sfr_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic cur_partial;
		logic cur_full;
		logic sh_stop;
		logic sh_full;
		logic rlen_zero;
		logic rep_last;
		logic out_free;
	} sfr_status_t;

endpackage
`default_nettype wire

@@ design/sfr_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_datapath
// Config registers, pending window, pattern compare and output register.
// ----------------------------------------------------------------------------
module sfr_datapath (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [sfr_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire [63:0]                     cfg_data,
	input  wire [7:0]                      in_char,
	input  sfr_pkg::sfr_cmd_t              cmd,
	output sfr_pkg::sfr_status_t           st,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [7:0]                     m_tdata,
	output logic                           m_tuser,
	output logic                           m_tlast
);
	import sfr_pkg::*;

	logic [CNT_W-1:0]                plen_q;
	logic [PAT_MAX*8-1:0]            pat_q;
	logic [CNT_W-1:0]                rlen_q;
	logic [REP_MAX*8-1:0]            rep_q;
	logic [CNT_W-1:0]                count_q;
	logic [WIN_DEPTH-1:0][7:0]       win_q;
	logic [2:0]                      rep_idx_q;
	logic                            out_valid_q;
	logic [7:0]                      out_char_q;
	logic                            out_is_char_q;
	logic                            out_last_q;

	logic [WIN_DEPTH-1:0][7:0]       win_sh;
	logic [CNT_W-1:0]                count_sh;
	logic [1:0]                      cur_j;
	logic [1:0]                      sh_j;
	logic [CNT_W-1:0]                base;
	logic [WIN_DEPTH-1:0][7:0]       win_n;
	logic [7:0]                      emit_char;

	function automatic logic [CNT_W-1:0] eff_plen(input logic [CNT_W-1:0] v);
		if (v == '0)
			return CNT_W'(1);
		else if (v > CNT_W'(PAT_MAX))
			return CNT_W'(PAT_MAX);
		else
			return v;
	endfunction

	function automatic logic [CNT_W-1:0] eff_rlen(input logic [CNT_W-1:0] v);
		if (v > CNT_W'(REP_MAX))
			return CNT_W'(REP_MAX);
		else
			return v;
	endfunction

	// {full match, partial match} of the first c bytes against the pattern
	function automatic logic [1:0] judge(
		input logic [WIN_DEPTH-1:0][7:0] w,
		input logic [CNT_W-1:0]          c,
		input logic [CNT_W-1:0]          pl,
		input logic [PAT_MAX*8-1:0]      pat
	);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (CNT_W'(i) < c && w[i] != pat[i*8 +: 8])
				ok = 1'b0;
		end
		return {ok && c == pl && c != '0, ok && c < pl && c != '0};
	endfunction

	assign win_sh   = {8'h00, win_q[WIN_DEPTH-1:1]};
	assign count_sh = count_q - CNT_W'(1);
	assign cur_j    = judge(win_q, count_q, plen_q, pat_q);
	assign sh_j     = judge(win_sh, count_sh, plen_q, pat_q);

	always_comb begin
		st.count_zero  = count_q == '0;
		st.cur_full    = cur_j[1];
		st.cur_partial = cur_j[0];
		st.sh_full     = count_q != '0 && sh_j[1];
		st.sh_stop     = count_q == CNT_W'(1) || sh_j[0];
		st.rlen_zero   = rlen_q == '0;
		st.rep_last    = (CNT_W'(rep_idx_q) + CNT_W'(1)) == rlen_q;
		st.out_free    = !out_valid_q || m_tready;
	end

	// count after pop or clear is where a pushed byte lands
	always_comb begin
		if (cmd.clear)
			base = '0;
		else if (cmd.pop)
			base = count_sh;
		else
			base = count_q;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_n[i] = cmd.pop ? win_sh[i] : win_q[i];
			if (cmd.push && base[2:0] == 3'(i))
				win_n[i] = in_char;
		end
	end

	always_comb begin
		case (cmd.sel)
			EMIT_WIN:  emit_char = win_q[0];
			EMIT_REP:  emit_char = rep_q[rep_idx_q*8 +: 8];
			default:   emit_char = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q      <= CNT_W'(1);
			pat_q       <= '0;
			rlen_q      <= '0;
			rep_q       <= '0;
			count_q     <= '0;
			rep_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_PATTERN_LEN) begin
				plen_q  <= eff_plen(cfg_data[CNT_W-1:0]);
				count_q <= '0;
			end else begin
				count_q <= cmd.push ? base + CNT_W'(1) : base;
			end
			if (cfg_we && cfg_index == REG_PATTERN_BYTES)
				pat_q <= cfg_data;
			if (cfg_we && cfg_index == REG_REPLACEMENT_LEN)
				rlen_q <= eff_rlen(cfg_data[CNT_W-1:0]);
			if (cfg_we && cfg_index == REG_REPLACEMENT_BYTES)
				rep_q <= cfg_data;
			if (cmd.rep_rst)
				rep_idx_q <= '0;
			else if (cmd.rep_inc)
				rep_idx_q <= rep_idx_q + 3'd1;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_n;
		if (cmd.emit) begin
			out_char_q    <= emit_char;
			out_is_char_q <= cmd.sel != EMIT_TERM;
			out_last_q    <= cmd.emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = out_is_char_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

@@ design/sfr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_ctrl
// Sequencer that walks the pending window and issues emit commands.
// ----------------------------------------------------------------------------
module sfr_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	input  wire                       s_tlast,
	input  sfr_pkg::sfr_status_t      st,
	output sfr_pkg::sfr_cmd_t         cmd
);
	import sfr_pkg::*;

	sfr_state_t state_q, state_n;
	logic       last_q, last_n;
	logic       fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			last_q  <= last_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		last_n   = last_q;
		cmd      = '0;
		cmd.sel  = EMIT_WIN;
		s_tready = 1'b0;
		fin      = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				fin = 1'b1;
			end
			ST_EVAL: begin
				if (st.count_zero || st.cur_partial) begin
					if (last_q)
						state_n = ST_FLUSH;
					else
						fin = 1'b1;
				end else if (st.cur_full) begin
					if (st.rlen_zero) begin
						cmd.clear = 1'b1;
						fin       = !last_q;
					end else begin
						cmd.rep_rst = 1'b1;
						state_n     = ST_REPL;
					end
				end else if (st.out_free) begin
					// head byte cannot start a match
					cmd.emit      = 1'b1;
					cmd.sel       = EMIT_WIN;
					cmd.pop       = 1'b1;
					cmd.emit_last = !last_q &&
						(st.sh_stop || (st.sh_full && st.rlen_zero));
					fin           = !last_q && st.sh_stop;
				end
			end
			ST_REPL: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.sel       = EMIT_REP;
					cmd.rep_inc   = 1'b1;
					cmd.emit_last = st.rep_last && !last_q;
					if (st.rep_last) begin
						cmd.clear = 1'b1;
						if (last_q)
							state_n = ST_EVAL;
						else
							fin = 1'b1;
					end
				end
			end
			ST_FLUSH: begin
				if (st.count_zero) begin
					state_n = ST_TERM;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = EMIT_WIN;
					cmd.pop  = 1'b1;
				end
			end
			ST_TERM: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.sel       = EMIT_TERM;
					cmd.emit_last = 1'b1;
					last_n        = 1'b0;
					state_n       = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		// window settled for this byte: take the next one in the same cycle
		if (fin) begin
			s_tready = 1'b1;
			if (s_tvalid) begin
				cmd.push = 1'b1;
				last_n   = s_tlast;
				state_n  = ST_EVAL;
			end else begin
				state_n  = ST_IDLE;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/stream_find_and_replace.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Byte stream find-and-replace with a pending window and end-of-string flush.
// ----------------------------------------------------------------------------
// Bytes come in one per word on s_*, the last byte of a string flagged by
// s_tlast. Each leftmost, non-overlapping match of the pattern is replaced by
// the replacement; bytes that may still begin a match are held until decided.
// A byte that passes straight through or is held is settled in ST_EVAL and
// the next byte is taken in the same cycle. A full match with a non-empty
// replacement enters ST_REPL, reading the replacement out of its register a
// byte a cycle. A byte that breaks a partial match releases held bytes one
// per cycle through the single output register until the rest may begin a
// match. On the last byte the held bytes are flushed one per cycle; once the
// window is empty, ST_TERM loads the terminator word (m_tuser low, data zero)
// and input is taken again in ST_IDLE. Any stall on m_tready holds the
// sequencer. Config writes are always taken and must only come while idle.
module stream_find_and_replace (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [7:0]                   s_tdata,   // in_char
	input  wire                          s_tlast,   // in_last
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [7:0]                   m_tdata,   // out_char
	output logic                         m_tuser,   // out_is_char
	output logic                         m_tlast,   // out_last
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [sfr_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire  [63:0]                  cfg_data
);
	import sfr_pkg::*;

	sfr_cmd_t    cmd;
	sfr_status_t st;

	assign cfg_ready = 1'b1;

	sfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.st       (st),
		.cmd      (cmd)
	);

	sfr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_char   (s_tdata),
		.cmd       (cmd),
		.st        (st),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// output register is only loaded when it is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> st.out_free)
		else $error("word loaded into a busy output register");

	// the last byte of a string is followed by flush, not another byte
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input taken right after end of string");

	// terminator always closes the results of its input
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 8'h00))
		else $error("terminator word malformed");

endmodule
`default_nettype wire
